### sv/pra_pkg.sv
// Package for the priority round-robin arbiter.
// Holds command and register index codes and fixed field widths; no dependencies.
package pra_pkg;

    localparam int LANE_FIELD_W = 4;
    localparam int PRIO_TABLE_W = 64;
    localparam int CFG_INDEX_W  = 8;

    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_RETIRE   = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_PRIORITY_TABLE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCHED_ENABLE   = 8'd1;

    localparam logic [PRIO_TABLE_W-1:0] PRIO_TABLE_RESET = 64'h1111_1111_1111_1111;

endpackage

### sv/priority_round_robin_arbiter.sv
// Priority round-robin arbiter top level: one compare unit stepped over the lanes.
// Depends on pra_pkg.
//
//  channel | direction | ports                                   | handshake
//  --------+-----------+-----------------------------------------+--------------------
//  s_      | in        | s_command, s_lane                       | s_valid / s_ready
//  m_      | out       | m_grant_valid, m_grant_lane, m_none_active | m_valid / m_ready
//  cfg_    | in        | cfg_index, cfg_data                     | cfg_valid / cfg_ready
//
// Retire: result is presented the cycle after the request is taken.
// Schedule: a minimum-priority pass over every lane, then a round-robin match pass from
// the pointer that stops at the first live lane at that minimum, then a done state that
// loads the result once the output is free; the single priority comparator walks the lanes.
// Reset (aresetn low, synchronous) restores the registers, marks all lanes active and
// clears the pointer. A stalled result holds the block; one request is in flight at a time.
module priority_round_robin_arbiter
    import pra_pkg::*;
#(
    parameter int LANES         = 16,
    parameter int PRIORITY_BITS = 4
) (
    input  logic                    aclk,
    input  logic                    aresetn,

    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_command,
    input  logic [LANE_FIELD_W-1:0] s_lane,

    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_grant_valid,
    output logic [LANE_FIELD_W-1:0] m_grant_lane,
    output logic                    m_none_active,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [PRIO_TABLE_W-1:0] cfg_data
);

    localparam int LANE_W = $clog2(LANES);
    localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(LANES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MIN  = 2'd1;
    localparam logic [1:0] ST_FIND = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [PRIO_TABLE_W-1:0]  prio_table_reg;
    logic                     enable_reg;
    logic [LANES-1:0]         active_reg,  active_next;
    logic [LANE_W-1:0]        start_reg,   start_next;
    logic [1:0]               state_reg,   state_next;
    logic [LANE_W-1:0]        idx_reg,     idx_next;
    logic [LANE_W-1:0]        cnt_reg,     cnt_next;
    logic [PRIORITY_BITS-1:0] best_reg,    best_next;
    logic                     found_reg,   found_next;
    logic [LANE_W-1:0]        win_reg,     win_next;

    logic                     m_valid_reg, m_valid_next;
    logic                     grant_valid_reg, grant_valid_next;
    logic [LANE_FIELD_W-1:0]  grant_lane_reg,  grant_lane_next;
    logic                     none_active_reg, none_active_next;

    logic                     s_take;
    logic                     out_free;
    logic [PRIORITY_BITS-1:0] cur_prio;
    logic                     cur_live;
    logic                     prio_lt;
    logic                     prio_eq;
    logic                     grant;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // shared compare unit: priority of the lane under the scan index against the best
    assign cur_prio = prio_table_reg[idx_reg*PRIORITY_BITS +: PRIORITY_BITS];
    assign cur_live = active_reg[idx_reg];
    assign prio_lt  = cur_prio < best_reg;
    assign prio_eq  = cur_prio == best_reg;
    assign grant    = found_reg && enable_reg;

    always_comb begin
        state_next       = state_reg;
        active_next      = active_reg;
        start_next       = start_reg;
        idx_next         = idx_reg;
        cnt_next         = cnt_reg;
        best_next        = best_reg;
        found_next       = found_reg;
        win_next         = win_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        grant_valid_next = grant_valid_reg;
        grant_lane_next  = grant_lane_reg;
        none_active_next = none_active_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    if (s_command == CMD_RETIRE) begin
                        if ({1'b0, s_lane} < (LANE_FIELD_W + 1)'(LANES)) begin
                            active_next[s_lane[LANE_W-1:0]] = 1'b0;
                        end
                        m_valid_next     = 1'b1;
                        grant_valid_next = 1'b0;
                        grant_lane_next  = '0;
                        none_active_next = (active_next == '0);
                    end else begin
                        state_next = ST_MIN;
                        idx_next   = '0;
                        cnt_next   = '0;
                        best_next  = '1;
                        found_next = 1'b0;
                        win_next   = '0;
                    end
                end
            end
            ST_MIN: begin
                if (cur_live && prio_lt) begin
                    best_next = cur_prio;
                end
                if (cnt_reg == LAST_LANE) begin
                    state_next = ST_FIND;
                    idx_next   = start_reg;
                    cnt_next   = '0;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIND: begin
                if (cur_live && prio_eq) begin
                    found_next = 1'b1;
                    win_next   = idx_reg;
                    state_next = ST_DONE;
                end else if (cnt_reg == LAST_LANE) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next = (idx_reg == LAST_LANE) ? '0 : idx_reg + 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next       = ST_IDLE;
                    m_valid_next     = 1'b1;
                    grant_valid_next = grant;
                    grant_lane_next  = grant ? LANE_FIELD_W'(win_reg) : '0;
                    none_active_next = (active_reg == '0);
                    if (grant) begin
                        start_next = (win_reg == LAST_LANE) ? '0 : win_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prio_table_reg <= PRIO_TABLE_RESET;
            enable_reg     <= 1'b1;
            active_reg     <= '1;
            start_reg      <= '0;
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_PRIORITY_TABLE) begin
                    prio_table_reg <= cfg_data;
                end else if (cfg_index == REG_SCHED_ENABLE) begin
                    enable_reg <= cfg_data[0];
                end
            end
            active_reg  <= active_next;
            start_reg   <= start_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg         <= idx_next;
        cnt_reg         <= cnt_next;
        best_reg        <= best_next;
        found_reg       <= found_next;
        win_reg         <= win_next;
        grant_valid_reg <= grant_valid_next;
        grant_lane_reg  <= grant_lane_next;
        none_active_reg <= none_active_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_grant_valid = grant_valid_reg;
    assign m_grant_lane  = grant_lane_reg;
    assign m_none_active = none_active_reg;

endmodule

### sv/pra_checker.sv
// Port-level checker for the priority round-robin arbiter, bound to the top level.
// Depends on pra_pkg and priority_round_robin_arbiter.
module pra_checker
    import pra_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    s_command,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic                    m_grant_valid,
    input logic [LANE_FIELD_W-1:0] m_grant_lane,
    input logic                    m_none_active
);

    // a retire request produces its result on the next cycle, never a grant
    a_retire_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_command == CMD_RETIRE |=> m_valid && !m_grant_valid)
        else $error("retire request did not produce a non-grant result");

    // a grant needs at least one active lane
    a_grant_live: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_grant_valid |-> !m_none_active)
        else $error("grant reported while no lane is active");

    a_no_grant_lane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_grant_valid |-> m_grant_lane == '0)
        else $error("lane index nonzero without a grant");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_grant_valid)
            && $stable(m_grant_lane) && $stable(m_none_active))
        else $error("stalled result changed");

endmodule

bind priority_round_robin_arbiter pra_checker u_pra_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_command     (s_command),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_grant_valid (m_grant_valid),
    .m_grant_lane  (m_grant_lane),
    .m_none_active (m_none_active)
);

### dv/priority_round_robin_arbiter_tb.sv
// Testbench for priority_round_robin_arbiter: directed and random schedule/retire traffic,
// checked result by result against a behavioral predictor of the grant logic.
// Depends on pra_pkg and the arbiter RTL.
module priority_round_robin_arbiter_tb;
    import pra_pkg::*;

    localparam int LANES            = 16;
    localparam int PRIO_W           = 4;
    localparam int MAX_SCHED_CYCLES = 2 * LANES + 1;
    localparam int MAX_PRINTED      = 100;

    // indexes past the register list; writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LOW  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HIGH = 8'hFF;

    typedef struct packed {
        logic                    grant_valid;
        logic [LANE_FIELD_W-1:0] grant_lane;
        logic                    none_active;
    } grant_result_t;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    logic                    s_command = CMD_SCHEDULE;
    logic [LANE_FIELD_W-1:0] s_lane    = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    logic                    m_grant_valid;
    logic [LANE_FIELD_W-1:0] m_grant_lane;
    logic                    m_none_active;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [PRIO_TABLE_W-1:0] cfg_data  = '0;

    // predictor state and its copy of the registers
    logic [LANES-1:0]        active_lanes   = '1;
    logic [LANE_FIELD_W-1:0] rr_pointer     = '0;
    logic [PRIO_TABLE_W-1:0] prio_word      = PRIO_TABLE_RESET;
    logic                    grants_enabled = 1'b1;

    grant_result_t grants_due[$];
    int            mismatches   = 0;
    int            results_seen = 0;
    int            burst_left   = 0;
    int            rx_left      = 0;
    logic          rx_stalling  = 1'b0;

    priority_round_robin_arbiter #(
        .LANES        (LANES),
        .PRIORITY_BITS(PRIO_W)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_lane       (s_lane),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_grant_valid(m_grant_valid),
        .m_grant_lane (m_grant_lane),
        .m_none_active(m_none_active),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAIL priority_round_robin_arbiter");
        $finish;
    end

    function automatic grant_result_t predict_grant(input logic cmd,
                                                    input logic [LANE_FIELD_W-1:0] lane);
        grant_result_t res;
        int            best;
        int            idx;
        int            k;
        logic          found;
        logic [LANE_FIELD_W-1:0] winner;
        res    = '0;
        best   = 1 << PRIO_W;
        found  = 1'b0;
        winner = '0;
        if (cmd == CMD_RETIRE) begin
            if (lane < LANES)
                active_lanes[lane] = 1'b0;
        end else begin
            for (idx = 0; idx < LANES; idx++)
                if (active_lanes[idx] && prio_word[idx*PRIO_W +: PRIO_W] < best)
                    best = prio_word[idx*PRIO_W +: PRIO_W];
            for (k = 0; k < LANES; k++) begin
                idx = (rr_pointer + k) % LANES;
                if (!found && active_lanes[idx] && prio_word[idx*PRIO_W +: PRIO_W] == best) begin
                    found  = 1'b1;
                    winner = LANE_FIELD_W'(idx);
                end
            end
            // pointer only moves on an actual grant
            if (found && grants_enabled) begin
                res.grant_valid = 1'b1;
                res.grant_lane  = winner;
                rr_pointer      = LANE_FIELD_W'((winner + 1) % LANES);
            end
        end
        res.none_active = (active_lanes == '0);
        return res;
    endfunction

    function automatic logic [PRIO_TABLE_W-1:0] tied_table(input int top);
        logic [PRIO_TABLE_W-1:0] word;
        int                      i;
        for (i = 0; i < LANES; i++)
            word[i*PRIO_W +: PRIO_W] = PRIO_W'($urandom_range(0, top));
        return word;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("MISMATCH: %s", what);
    endtask

    // receiver: alternating ready and stall runs, sometimes long ready stretches
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_stalling = !rx_stalling;
            if (rx_stalling)
                rx_left = $urandom_range(1, 8);
            else if ($urandom_range(0, 9) == 0)
                rx_left = $urandom_range(50, 300);
            else
                rx_left = $urandom_range(1, 6);
        end
        rx_left--;
        m_ready <= !rx_stalling;
    end

    always @(posedge aclk) begin : check_results
        grant_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (grants_due.size() == 0) begin
                report_mismatch($sformatf("result %0d with no request pending: valid=%0b lane=%0d none=%0b",
                    results_seen, m_grant_valid, m_grant_lane, m_none_active));
            end else begin
                want = grants_due.pop_front();
                if (m_grant_valid !== want.grant_valid || m_grant_lane !== want.grant_lane ||
                    m_none_active !== want.none_active)
                    report_mismatch($sformatf(
                        "result %0d: got valid=%0b lane=%0d none=%0b, want valid=%0b lane=%0d none=%0b",
                        results_seen, m_grant_valid, m_grant_lane, m_none_active,
                        want.grant_valid, want.grant_lane, want.none_active));
            end
        end
    end

    // one request; valid stays up inside a burst and drops for a random gap after it
    task automatic send_request(input logic cmd, input logic [LANE_FIELD_W-1:0] lane);
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_lane    <= lane;
        do @(posedge aclk); while (!s_ready);
        grants_due.push_back(predict_grant(cmd, lane));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (grants_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [PRIO_TABLE_W-1:0] data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == REG_PRIORITY_TABLE)
            prio_word = data;
        else if (index == REG_SCHED_ENABLE)
            grants_enabled = data[0];
        @(posedge aclk);
    endtask

    task automatic test_reset_state();
        send_request(CMD_SCHEDULE, 4'hF);
        send_request(CMD_SCHEDULE, 4'h0);
        send_request(CMD_SCHEDULE, 4'hA);
    endtask

    task automatic test_priority_extremes();
        // only the top lane at priority zero: repeated wins wrap the pointer
        write_register(REG_PRIORITY_TABLE, 64'h0FFF_FFFF_FFFF_FFFF);
        send_request(CMD_SCHEDULE, 4'h5);
        send_request(CMD_SCHEDULE, 4'h5);
        write_register(REG_PRIORITY_TABLE, '1);
        send_request(CMD_SCHEDULE, 4'h0);
    endtask

    task automatic test_enable_gate();
        // only bit 0 of the write data counts
        write_register(REG_SCHED_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE);
        send_request(CMD_SCHEDULE, 4'h3);
        send_request(CMD_SCHEDULE, 4'hC);
        write_register(REG_SCHED_ENABLE, 64'h1);
        send_request(CMD_SCHEDULE, 4'h3);
    endtask

    task automatic test_retire();
        send_request(CMD_RETIRE, 4'hF);
        send_request(CMD_RETIRE, 4'h3);
        send_request(CMD_RETIRE, 4'h3);
        send_request(CMD_SCHEDULE, 4'h0);
        send_request(CMD_SCHEDULE, 4'h0);
    endtask

    task automatic test_unmapped_registers();
        write_register(REG_UNMAPPED_LOW, '0);
        write_register(REG_UNMAPPED_HIGH, '1);
        send_request(CMD_SCHEDULE, 4'h9);
    endtask

    task automatic run_traffic(input int count);
        int                      n;
        int                      i;
        int                      live;
        logic [LANE_FIELD_W-1:0] lane;
        for (n = 0; n < count; n++) begin
            lane = LANE_FIELD_W'($urandom_range(0, LANES - 1));
            if ($urandom_range(0, 24) == 0) begin
                live = 0;
                for (i = 0; i < LANES; i++)
                    live += active_lanes[i];
                // retire can't be undone, so keep a handful of lanes in play
                while (live <= 4 && active_lanes[lane])
                    lane = lane + 1'b1;
                send_request(CMD_RETIRE, lane);
            end else begin
                send_request(CMD_SCHEDULE, lane);
            end
            if ($urandom_range(0, 149) == 0)
                wait_idle();
        end
    endtask

    task automatic test_random_traffic();
        write_register(REG_PRIORITY_TABLE, PRIO_TABLE_RESET);
        run_traffic(250);
        write_register(REG_PRIORITY_TABLE, {$urandom, $urandom});
        run_traffic(250);
        write_register(REG_PRIORITY_TABLE, tied_table(2));
        run_traffic(250);
        write_register(REG_PRIORITY_TABLE, '0);
        run_traffic(250);
        write_register(REG_PRIORITY_TABLE, '1);
        write_register(REG_SCHED_ENABLE, '1);
        run_traffic(250);
        write_register(REG_SCHED_ENABLE, {$urandom, $urandom} & ~64'd1);
        write_register(REG_PRIORITY_TABLE, {$urandom, $urandom});
        run_traffic(200);
        write_register(REG_SCHED_ENABLE, 64'd1);
        write_register(REG_PRIORITY_TABLE, tied_table(1));
        run_traffic(300);
    endtask

    // draining every lane is permanent short of reset, so this runs last
    task automatic test_drain_all();
        int i;
        for (i = 0; i < LANES; i++)
            send_request(CMD_RETIRE, LANE_FIELD_W'(i));
        send_request(CMD_SCHEDULE, 4'h7);
        write_register(REG_SCHED_ENABLE, 64'd0);
        send_request(CMD_SCHEDULE, 4'h8);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_priority_extremes();
        test_enable_gate();
        test_retire();
        test_unmapped_registers();
        test_random_traffic();
        test_drain_all();
        wait_idle();
        repeat (MAX_SCHED_CYCLES) @(posedge aclk);
        if (mismatches == 0 && grants_due.size() == 0)
            $display("PASS priority_round_robin_arbiter");
        else
            $display("FAIL priority_round_robin_arbiter");
        $finish;
    end

endmodule

### priority_round_robin_arbiter.f
sv/pra_pkg.sv
sv/priority_round_robin_arbiter.sv
sv/pra_checker.sv
dv/priority_round_robin_arbiter_tb.sv
